### rtl/von_mises_basis_evaluator_defines.svh
// ----------------------------------------------------------------------------
// Von Mises basis evaluator assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef VON_MISES_BASIS_EVALUATOR_DEFINES_SVH
`define VON_MISES_BASIS_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check that is suspended while reset is asserted
`define VMB_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check that also holds during reset
`define VMB_ASSERT_ALL(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define VMB_ASSERT_RST(name, prop, msg)
`define VMB_ASSERT_ALL(name, prop, msg)
`endif

`endif

### rtl/vmb_pkg.sv
// ----------------------------------------------------------------------------
// Von Mises basis evaluator package
// Shared constants, state type and divider reciprocal table.
// ----------------------------------------------------------------------------
`default_nettype none

package vmb_pkg;

    localparam int NUM_BASIS = 16;
    localparam int IDX_W     = (NUM_BASIS > 1) ? $clog2(NUM_BASIS) : 1;

    localparam logic [1:0] FUNC_EVAL   = 2'd0;
    localparam logic [1:0] FUNC_LOAD_C = 2'd1;
    localparam logic [1:0] FUNC_LOAD_W = 2'd2;

    localparam logic [18:0] TWO_PI_Q12  = 19'd25736;
    localparam logic [18:0] THREE_2PI   = 19'd77208;
    localparam logic [18:0] PI_Q12      = 19'd12868;
    localparam logic [18:0] HALF_PI_Q12 = 19'd6434;
    localparam logic [24:0] LOG2E_Q24   = 25'd24204406;
    localparam logic [23:0] LN2_Q24     = 24'd11629080;
    localparam logic [24:0] ONE_Q24     = 25'd16777216;
    localparam int          RECIP_SHIFT = 31;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_ANG,
        S_SQ,
        S_DIVM,
        S_DIVS,
        S_UMUL,
        S_KM,
        S_LOG,
        S_FRAC,
        S_EMUL,
        S_OUT
    } t_state;

    // Divisor used by each step of the cosine polynomial
    function automatic logic [5:0] cos_div(input logic [1:0] step);
        logic [5:0] d;
        case (step)
            2'd0:    d = 6'd56;
            2'd1:    d = 6'd30;
            2'd2:    d = 6'd12;
            default: d = 6'd2;
        endcase
        return d;
    endfunction

    // ceil(2^31 / d): exact floor quotient for 25-bit dividends
    function automatic logic [31:0] recip(input logic [5:0] d);
        logic [31:0] m;
        case (d)
            6'd1:    m = 32'd2147483648;
            6'd2:    m = 32'd1073741824;
            6'd3:    m = 32'd715827883;
            6'd4:    m = 32'd536870912;
            6'd5:    m = 32'd429496730;
            6'd6:    m = 32'd357913942;
            6'd7:    m = 32'd306783379;
            6'd8:    m = 32'd268435456;
            6'd12:   m = 32'd178956971;
            6'd30:   m = 32'd71582789;
            6'd56:   m = 32'd38347923;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/vmb_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vmb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                 i_wdata,
    input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/von_mises_basis_evaluator.sv
// ----------------------------------------------------------------------------
// Von Mises basis evaluator
// Holds basis centers and widths and emits exp(h*(cos(x-c)-1)) per basis.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: tuser[1:0] selects the operation (evaluate, load center,
//   load width); tdata carries phase, entry index, center and width.
//   Load transactions write one entry in the accept cycle and give no result.
//   An evaluate transaction yields NUM_BASIS master transactions in index
//   order; tlast marks the final one.
//   Each basis takes one memory read, angle reduction, the cosine
//   polynomial and the exponential, both of the latter through one
//   shared multiplier-by-reciprocal divider.
//   The slave side is ready only while the sequencer is idle.
//   A stalled master side holds the result register and freezes the
//   sequencer at its output step; no result is dropped.
//   Reset (synchronous, active low) clears the sequencer and output valid;
//   the center and width memories keep no reset value and must be loaded
//   before they are evaluated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "von_mises_basis_evaluator_defines.svh"

module von_mises_basis_evaluator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // phase_value[15:0], entry_index[19:16], center_value[35:20],
    // width_value[51:36], zero pad[55:52]
    input  wire  [55:0] i_s_tdata,
    // func[1:0]
    input  wire  [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // activation[15:0], basis_number[19:16], zero pad[23:20]
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast
);

    localparam int IW = vmb_pkg::IDX_W;

    // Slave field breakout
    logic [15:0] s_phase;
    logic [3:0]  s_index;
    logic [15:0] s_center;
    logic [15:0] s_width;
    logic        s_accept;
    logic        s_index_ok;

    assign s_phase    = i_s_tdata[15:0];
    assign s_index    = i_s_tdata[19:16];
    assign s_center   = i_s_tdata[35:20];
    assign s_width    = i_s_tdata[51:36];
    assign s_index_ok = (int'(s_index) < vmb_pkg::NUM_BASIS);

    // Sequencer and datapath registers
    vmb_pkg::t_state r_state, n_state;
    logic [IW-1:0]  r_idx,  n_idx;
    logic [15:0]    r_x,    n_x;
    logic [15:0]    r_h,    n_h;
    logic [16:0]    r_s,    n_s;
    logic           r_neg,  n_neg;
    logic [17:0]    r_u,    n_u;
    logic [24:0]    r_num,  n_num;
    logic [56:0]    r_prod, n_prod;
    logic [1:0]     r_step, n_step;
    logic [3:0]     r_j,    n_j;
    logic           r_expm, n_expm;
    logic [16:0]    r_p,    n_p;
    logic signed [18:0] r_k, n_k;
    logic [33:0]    r_m,    n_m;
    logic [33:0]    r_y,    n_y;
    logic [23:0]    r_g,    n_g;
    logic [24:0]    r_q,    n_q;
    logic           r_ov,   n_ov;
    logic [15:0]    r_act,  n_act;
    logic [3:0]     r_bn,   n_bn;
    logic           r_last, n_last;

    assign o_s_tready = (r_state == vmb_pkg::S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Entry memories
    logic [15:0] c_rdata;
    logic [15:0] h_rdata;

    vmb_ram #(.WIDTH(16), .DEPTH(vmb_pkg::NUM_BASIS)) u_center_ram (
        .i_clk   (i_clk),
        .i_we    (s_accept && (i_s_tuser == vmb_pkg::FUNC_LOAD_C) && s_index_ok),
        .i_waddr (IW'(s_index)),
        .i_wdata (s_center),
        .i_raddr (r_idx),
        .o_rdata (c_rdata)
    );

    vmb_ram #(.WIDTH(16), .DEPTH(vmb_pkg::NUM_BASIS)) u_width_ram (
        .i_clk   (i_clk),
        .i_we    (s_accept && (i_s_tuser == vmb_pkg::FUNC_LOAD_W) && s_index_ok),
        .i_waddr (IW'(s_index)),
        .i_wdata (s_width),
        .i_raddr (r_idx),
        .o_rdata (h_rdata)
    );

    // Angle reduction of x - c into [0, pi/2] with sign of the cosine
    logic signed [18:0] a_d;
    logic [18:0] a_t0, a_t1, a_t2, a_t3, a_t4;
    logic        a_neg;

    always_comb begin
        a_d  = $signed({{3{r_x[15]}}, r_x}) - $signed({{3{c_rdata[15]}}, c_rdata});
        a_t0 = a_d[18] ? 19'(a_d + $signed(vmb_pkg::THREE_2PI)) : 19'(a_d);
        a_t1 = (a_t0 >= vmb_pkg::TWO_PI_Q12) ? a_t0 - vmb_pkg::TWO_PI_Q12 : a_t0;
        a_t2 = (a_t1 >= vmb_pkg::TWO_PI_Q12) ? a_t1 - vmb_pkg::TWO_PI_Q12 : a_t1;
        a_t3 = (a_t2 > vmb_pkg::PI_Q12) ? vmb_pkg::TWO_PI_Q12 - a_t2 : a_t2;
        a_neg = (a_t3 > vmb_pkg::HALF_PI_Q12);
        a_t4 = a_neg ? vmb_pkg::PI_Q12 - a_t3 : a_t3;
    end

    // Shared divide-by-constant: multiply by reciprocal, then shift
    logic [5:0]  dv_div;
    logic [25:0] dv_quo;

    assign dv_div = r_expm ? {2'b00, r_j} : vmb_pkg::cos_div(r_step);
    assign dv_quo = r_prod[56:vmb_pkg::RECIP_SHIFT];

    // Cosine finish and activation scaling
    logic signed [18:0] k_clamp;
    logic signed [18:0] k_cos;
    logic signed [18:0] k_om;
    logic [9:0]         o_n;
    logic [4:0]         o_sh;
    logic [24:0]        o_r;
    logic [15:0]        o_act;

    always_comb begin
        k_clamp = r_k;
        if (r_k > 19'sd65536) begin
            k_clamp = 19'sd65536;
        end else if (r_k < -19'sd65536) begin
            k_clamp = -19'sd65536;
        end
        k_cos = r_neg ? -k_clamp : k_clamp;
        k_om  = 19'sd65536 - k_cos;

        o_n  = r_y[33:24];
        o_sh = 5'(o_n) + 5'd8;
        o_r  = r_q >> o_sh;
        if (o_n > 10'd16) begin
            o_act = 16'd0;
        end else if (o_r > 25'd65535) begin
            o_act = 16'hFFFF;
        end else begin
            o_act = o_r[15:0];
        end
    end

    // Next state and datapath
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_x     = r_x;
        n_h     = r_h;
        n_s     = r_s;
        n_neg   = r_neg;
        n_u     = r_u;
        n_num   = r_num;
        n_prod  = r_prod;
        n_step  = r_step;
        n_j     = r_j;
        n_expm  = r_expm;
        n_p     = r_p;
        n_k     = r_k;
        n_m     = r_m;
        n_y     = r_y;
        n_g     = r_g;
        n_q     = r_q;
        n_ov    = r_ov && !i_m_tready;
        n_act   = r_act;
        n_bn    = r_bn;
        n_last  = r_last;

        case (r_state)
            vmb_pkg::S_IDLE: begin
                // Loads write the memory directly; only evaluate starts a run
                if (s_accept && (i_s_tuser == vmb_pkg::FUNC_EVAL)) begin
                    n_x     = s_phase;
                    n_idx   = '0;
                    n_state = vmb_pkg::S_RD;
                end
            end
            vmb_pkg::S_RD: begin
                n_state = vmb_pkg::S_ANG;
            end
            vmb_pkg::S_ANG: begin
                n_h     = h_rdata;
                n_neg   = a_neg;
                n_s     = {a_t4[12:0], 4'b0000};
                n_state = vmb_pkg::S_SQ;
            end
            vmb_pkg::S_SQ: begin
                n_u     = 18'((34'(r_s) * 34'(r_s)) >> 16);
                n_num   = 25'((34'(r_s) * 34'(r_s)) >> 16);
                n_step  = 2'd0;
                n_expm  = 1'b0;
                n_state = vmb_pkg::S_DIVM;
            end
            vmb_pkg::S_DIVM: begin
                n_prod  = 57'(r_num) * 57'(vmb_pkg::recip(dv_div));
                n_state = vmb_pkg::S_DIVS;
            end
            vmb_pkg::S_DIVS: begin
                if (r_expm) begin
                    n_q = vmb_pkg::ONE_Q24 - 25'(dv_quo);
                    if (r_j == 4'd1) begin
                        n_state = vmb_pkg::S_OUT;
                    end else begin
                        n_j     = r_j - 4'd1;
                        n_state = vmb_pkg::S_EMUL;
                    end
                end else if (r_step == 2'd3) begin
                    n_k     = 19'sd65536 - $signed(19'(dv_quo));
                    n_state = vmb_pkg::S_KM;
                end else begin
                    n_p     = 17'(26'd65536 - dv_quo);
                    n_step  = r_step + 2'd1;
                    n_state = vmb_pkg::S_UMUL;
                end
            end
            vmb_pkg::S_UMUL: begin
                n_num   = 25'((35'(r_u) * 35'(r_p)) >> 16);
                n_state = vmb_pkg::S_DIVM;
            end
            vmb_pkg::S_KM: begin
                n_m     = 34'(r_h) * 34'(k_om[17:0]);
                n_state = vmb_pkg::S_LOG;
            end
            vmb_pkg::S_LOG: begin
                n_y     = 34'((59'(r_m) * 59'(vmb_pkg::LOG2E_Q24)) >> 24);
                n_state = vmb_pkg::S_FRAC;
            end
            vmb_pkg::S_FRAC: begin
                n_g     = 24'((48'(r_y[23:0]) * 48'(vmb_pkg::LN2_Q24)) >> 24);
                n_q     = vmb_pkg::ONE_Q24;
                n_j     = 4'd8;
                n_expm  = 1'b1;
                n_state = vmb_pkg::S_EMUL;
            end
            vmb_pkg::S_EMUL: begin
                n_num   = 25'((49'(r_g) * 49'(r_q)) >> 24);
                n_state = vmb_pkg::S_DIVM;
            end
            vmb_pkg::S_OUT: begin
                // Hold here until the result register is free
                if (!r_ov || i_m_tready) begin
                    n_ov   = 1'b1;
                    n_act  = o_act;
                    n_bn   = 4'(r_idx);
                    n_last = (r_idx == IW'(vmb_pkg::NUM_BASIS - 1));
                    if (r_idx == IW'(vmb_pkg::NUM_BASIS - 1)) begin
                        n_state = vmb_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = vmb_pkg::S_RD;
                    end
                end
            end
            default: begin
                n_state = vmb_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vmb_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_x    <= n_x;
        r_h    <= n_h;
        r_s    <= n_s;
        r_neg  <= n_neg;
        r_u    <= n_u;
        r_num  <= n_num;
        r_prod <= n_prod;
        r_step <= n_step;
        r_j    <= n_j;
        r_expm <= n_expm;
        r_p    <= n_p;
        r_k    <= n_k;
        r_m    <= n_m;
        r_y    <= n_y;
        r_g    <= n_g;
        r_q    <= n_q;
        r_act  <= n_act;
        r_bn   <= n_bn;
        r_last <= n_last;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {4'b0000, r_bn, r_act};
    assign o_m_tlast  = r_last;

    // An accepted evaluate blocks the slave side for its whole run
    `VMB_ASSERT_RST(a_eval_busy,
        (s_accept && (i_s_tuser == vmb_pkg::FUNC_EVAL)) |=> !o_s_tready,
        "slave ready right after an evaluate transaction")
    // The flagged result belongs to the final basis
    `VMB_ASSERT_RST(a_last_index,
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[19:16] == 4'(vmb_pkg::NUM_BASIS - 1)),
        "last flag on a basis other than the final one")
    // A blocked result register freezes the sequencer at its output step
    `VMB_ASSERT_RST(a_out_hold,
        (r_state == vmb_pkg::S_OUT && r_ov && !i_m_tready) |=> (r_state == vmb_pkg::S_OUT),
        "sequencer advanced past a stalled result")

endmodule

`default_nettype wire
